// ----- rtl/mqtt_frame_parser_macros.svh -----
// assertion macros shared by the checker of the mqtt frame parser
`ifndef MQTT_FRAME_PARSER_MACROS_SVH
`define MQTT_FRAME_PARSER_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define MQFP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mqfp assertion failed");

// next-cycle implication, disabled while reset is held
`define MQFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mqfp assertion failed");

`endif

// ----- rtl/mqfp_pkg.sv -----
// shared types and constants of the mqtt frame parser
package mqfp_pkg;

    localparam int MAX_LENGTH_BYTES_DEF = 4;
    localparam int QUEUE_DEPTH          = 4;
    localparam int POS_W                = 28;

    localparam logic [3:0] TYPE_CONNACK = 4'd2;
    localparam logic [3:0] TYPE_PUBLISH = 4'd3;

    localparam logic [1:0] EV_BODY      = 2'd0;
    localparam logic [1:0] EV_EMPTY     = 2'd1;
    localparam logic [1:0] EV_MALFORMED = 2'd2;

    localparam logic [1:0] SEC_OTHER   = 2'd0;
    localparam logic [1:0] SEC_TOPIC   = 2'd1;
    localparam logic [1:0] SEC_PAYLOAD = 2'd2;
    localparam logic [1:0] SEC_DISCARD = 2'd3;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_RESET = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_BODY   = 2'd2,
        PH_HALTED = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ITEM_BODY      = 2'd0,
        ITEM_EMPTY     = 2'd1,
        ITEM_MALFORMED = 2'd2,
        ITEM_RESET     = 2'd3
    } item_kind_t;

    // classified word handed from the front to the back
    typedef struct packed {
        item_kind_t         kind;
        logic [3:0]         ptype;
        logic [7:0]         data;
        logic [POS_W-1:0]   pos;
        logic               last;
        logic [POS_W-1:0]   frame_len;
    } qitem_t;

endpackage

// ----- rtl/mqfp_front.sv -----
// front end: fixed header and remaining length decode, classifies each byte
module mqfp_front #(
    parameter int MAX_LENGTH_BYTES = mqfp_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic            opcode,
    input  logic [7:0]      rx_byte,
    output logic            push,
    output mqfp_pkg::qitem_t item
);
    import mqfp_pkg::*;

    localparam logic [2:0] MAX_CNT = 3'(MAX_LENGTH_BYTES);

    phase_t            phase_reg, phase_next;
    logic [3:0]        type_reg, type_next;
    logic [POS_W-1:0]  len_reg, len_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [POS_W-1:0]  remain_reg, remain_next;
    logic [POS_W-1:0]  index_reg, index_next;

    logic [2:0]        cnt_inc;
    logic [POS_W-1:0]  len_sum;
    logic [POS_W-1:0]  group;
    logic [POS_W-1:0]  remain_dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            type_reg   <= '0;
            len_reg    <= '0;
            cnt_reg    <= '0;
            remain_reg <= '0;
            index_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            len_reg    <= len_next;
            cnt_reg    <= cnt_next;
            remain_reg <= remain_next;
            index_reg  <= index_next;
        end
    end

    always_comb
    begin
        cnt_inc    = cnt_reg + 3'd1;
        remain_dec = remain_reg - POS_W'(1);
        case (cnt_reg[1:0])
            2'd0:    group = POS_W'(rx_byte[6:0]);
            2'd1:    group = POS_W'(rx_byte[6:0]) << 7;
            2'd2:    group = POS_W'(rx_byte[6:0]) << 14;
            default: group = POS_W'(rx_byte[6:0]) << 21;
        endcase
        len_sum = len_reg + group;

        phase_next  = phase_reg;
        type_next   = type_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        remain_next = remain_reg;
        index_next  = index_reg;

        push            = 1'b0;
        item.kind       = ITEM_BODY;
        item.ptype      = type_reg;
        item.data       = '0;
        item.pos        = '0;
        item.last       = 1'b0;
        item.frame_len  = len_reg;

        if (accept)
        begin
            if (opcode == OP_RESET)
            begin
                phase_next  = PH_HEADER;
                type_next   = '0;
                len_next    = '0;
                cnt_next    = '0;
                remain_next = '0;
                index_next  = '0;
                push        = 1'b1;
                item.kind   = ITEM_RESET;
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        type_next  = rx_byte[7:4];
                        len_next   = '0;
                        cnt_next   = '0;
                        phase_next = PH_LENGTH;
                    end
                    PH_LENGTH:
                    begin
                        len_next = len_sum;
                        cnt_next = cnt_inc;
                        if (rx_byte[7])
                        begin
                            if (cnt_inc >= MAX_CNT)
                            begin
                                phase_next = PH_HALTED;
                                push       = 1'b1;
                                item.kind  = ITEM_MALFORMED;
                            end
                        end
                        else
                        begin
                            remain_next = len_sum;
                            index_next  = '0;
                            if (len_sum == '0)
                            begin
                                phase_next = PH_HEADER;
                                push       = 1'b1;
                                item.kind  = ITEM_EMPTY;
                                item.last  = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_BODY;
                            end
                        end
                    end
                    PH_BODY:
                    begin
                        push        = 1'b1;
                        item.kind   = ITEM_BODY;
                        item.data   = rx_byte;
                        item.pos    = index_reg;
                        item.last   = (remain_dec == '0);
                        index_next  = index_reg + POS_W'(1);
                        remain_next = remain_dec;
                        if (remain_dec == '0)
                        begin
                            phase_next = PH_HEADER;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HALTED;
                    end
                endcase
            end
        end
    end

endmodule

// ----- rtl/mqfp_queue.sv -----
// short word queue between the front and the back
module mqfp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mqfp_pkg::qitem_t push_item,
    input  logic             pop,
    output mqfp_pkg::qitem_t head_item,
    output logic             empty,
    output logic             full
);
    import mqfp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W:0] DEPTH_CNT = (PTR_W + 1)'(QUEUE_DEPTH);

    qitem_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]    count_reg;

    logic do_push, do_pop;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == DEPTH_CNT);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + (PTR_W + 1)'(1);
                2'b01:   count_reg <= count_reg - (PTR_W + 1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- rtl/mqfp_back.sv -----
// back end: publish sections, connack flag and the output register
module mqfp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  mqfp_pkg::qitem_t head_item,
    input  logic             q_empty,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [47:0]      m_tdata,
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);
    import mqfp_pkg::*;

    logic [15:0]       topic_reg, topic_next;
    logic              pvalid_reg, pvalid_next;
    logic              conn_reg, conn_next;
    logic              ovalid_reg, ovalid_next;

    logic [1:0]        ev_reg, ev_next;
    logic [3:0]        ptype_reg;
    logic [7:0]        data_reg;
    logic [1:0]        sec_reg, sec_next;
    logic [POS_W-1:0]  pos_reg;
    logic              last_reg;
    logic              oconn_reg;

    logic              is_reset;
    logic              load;
    logic              len_short;
    logic              pos_zero, pos_one;
    logic [16:0]       topic_end_next;
    logic [16:0]       topic_end;

    assign is_reset  = (head_item.kind == ITEM_RESET);
    assign pop       = !q_empty && (is_reset || !ovalid_reg || m_tready);
    assign load      = pop && !is_reset;
    assign len_short = (head_item.frame_len[POS_W-1:1] == '0);
    assign pos_zero  = (head_item.pos == '0);
    assign pos_one   = (head_item.pos == POS_W'(1));

    always_comb
    begin
        topic_next     = topic_reg;
        pvalid_next    = pvalid_reg;
        conn_next      = conn_reg;
        sec_next       = SEC_OTHER;
        topic_end      = 17'({1'b0, topic_reg} + 17'd2);
        topic_end_next = 17'd0;

        case (head_item.kind)
            ITEM_EMPTY:     ev_next = EV_EMPTY;
            ITEM_MALFORMED: ev_next = EV_MALFORMED;
            default:        ev_next = EV_BODY;
        endcase

        if (pop && is_reset)
        begin
            topic_next  = '0;
            pvalid_next = 1'b0;
            conn_next   = 1'b0;
        end
        else if (load && head_item.kind == ITEM_BODY)
        begin
            if (head_item.ptype == TYPE_PUBLISH)
            begin
                if (len_short)
                begin
                    sec_next = SEC_DISCARD;
                end
                else if (pos_zero)
                begin
                    topic_next = {head_item.data, 8'h00};
                end
                else if (pos_one)
                begin
                    topic_next     = {topic_reg[15:8], head_item.data};
                    topic_end_next = 17'({1'b0, topic_next} + 17'd2);
                    pvalid_next    = (POS_W'(topic_end_next) <= head_item.frame_len);
                end
                else if (!pvalid_reg)
                begin
                    sec_next = SEC_DISCARD;
                end
                else if (head_item.pos < POS_W'(topic_end))
                begin
                    sec_next = SEC_TOPIC;
                end
                else
                begin
                    sec_next = SEC_PAYLOAD;
                end
            end
            else if (head_item.ptype == TYPE_CONNACK)
            begin
                if (pos_one && !len_short && head_item.data == 8'h00)
                begin
                    conn_next = 1'b1;
                end
            end
        end

        if (load)
        begin
            ovalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            ovalid_next = 1'b0;
        end
        else
        begin
            ovalid_next = ovalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            topic_reg  <= '0;
            pvalid_reg <= 1'b0;
            conn_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            topic_reg  <= topic_next;
            pvalid_reg <= pvalid_next;
            conn_reg   <= conn_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ev_reg    <= ev_next;
            ptype_reg <= head_item.ptype;
            data_reg  <= head_item.data;
            sec_reg   <= sec_next;
            pos_reg   <= head_item.pos;
            last_reg  <= head_item.last;
            oconn_reg <= conn_next;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tuser  = ev_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {5'b0, oconn_reg, pos_reg, sec_reg, data_reg, ptype_reg};

endmodule

// ----- rtl/mqtt_frame_parser.sv -----
// top level of the mqtt 3.1.1 receive-side fixed header parser
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tdata rx_byte, tuser opcode
//  m_*     | out | m_tvalid/m_tready  | tdata type/byte/section/pos/connected,
//          |     |                    | tuser event, tlast end of frame
//
//  one input word per cycle; s_tready drops only while the four-word queue
//  between front and back is full
//  header and length bytes leave no word; every body byte, empty frame and
//  malformed length leaves one, through the queue and then the output register
//  the output register lets the back take the next queued word in the same
//  cycle that the current result is taken
//  rst_n clears all control state asynchronously; a connection reset word
//  clears the parser at once and the connected flag when it reaches the back
module mqtt_frame_parser #(
    parameter int MAX_LENGTH_BYTES = mqfp_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [3:0] packet_type, [11:4] body_byte,
                                   // [13:12] section, [41:14] body_position,
                                   // [42] connected, [47:43] zero
    output logic [1:0]  m_tuser,   // [1:0] event_res
    output logic        m_tlast    // last_of_frame
);
    import mqfp_pkg::*;

    logic   accept;
    logic   push;
    logic   pop;
    logic   q_empty;
    logic   q_full;
    qitem_t push_item;
    qitem_t head_item;

    // input side only waits on queue space
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    mqfp_front #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .opcode  (s_tuser),
        .rx_byte (s_tdata),
        .push    (push),
        .item    (push_item)
    );

    mqfp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .empty     (q_empty),
        .full      (q_full)
    );

    // back side: per-frame publish state and the result register
    mqfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_item (head_item),
        .q_empty   (q_empty),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- rtl/mqfp_checker.sv -----
// port-level checker of the mqtt frame parser and its bind
`include "mqtt_frame_parser_macros.svh"

module mqfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import mqfp_pkg::*;

    `MQFP_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    `MQFP_ASSERT_IMPL(a_event_code, clk, rst_n, m_tvalid, m_tuser == EV_BODY || m_tuser == EV_EMPTY || m_tuser == EV_MALFORMED)

    `MQFP_ASSERT_IMPL(a_empty_frame, clk, rst_n, m_tvalid && m_tuser == EV_EMPTY, m_tlast && m_tdata[41:4] == '0)

    `MQFP_ASSERT_IMPL(a_malformed, clk, rst_n, m_tvalid && m_tuser == EV_MALFORMED, !m_tlast && m_tdata[41:4] == '0)

    `MQFP_ASSERT_IMPL(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[47:43] == '0)

endmodule

bind mqtt_frame_parser mqfp_checker u_mqfp_checker (.*);

// ----- test/mqtt_frame_parser_chk.sv -----
// checker for the mqtt frame parser: mirrors the parse of every word and compares the results
module mqtt_frame_parser_chk #(
    parameter int MAX_LEN = mqfp_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending,
    output int          result_count,
    output int          body_count,
    output int          empty_count,
    output int          malformed_count
);
    import mqfp_pkg::*;

    typedef struct packed {
        logic [1:0]       ev;
        logic [3:0]       ptype;
        logic [7:0]       data;
        logic [1:0]       sec;
        logic [POS_W-1:0] pos;
        logic             last;
        logic             conn;
        logic [4:0]       pad;
    } frame_result_t;

    frame_result_t expected_q[$];

    // mirrored parser state
    phase_t           phase;
    logic [3:0]       ftype;
    logic [POS_W-1:0] len_acc;
    logic [2:0]       len_cnt;
    logic [POS_W-1:0] remaining;
    logic [POS_W-1:0] index;
    logic [15:0]      topic_len;
    logic             pub_ok;
    logic             conn;

    task automatic clear_parser();
        phase     = PH_HEADER;
        ftype     = '0;
        len_acc   = '0;
        len_cnt   = '0;
        remaining = '0;
        index     = '0;
        topic_len = '0;
        pub_ok    = 1'b0;
        conn      = 1'b0;
    endtask

    task automatic parse_word(input logic op, input logic [7:0] b);
        frame_result_t    res;
        logic             emit;
        logic [POS_W-1:0] pos;
        res  = '0;
        emit = 1'b0;
        if (op == OP_RESET)
        begin
            clear_parser();
            return;
        end
        case (phase)
            PH_HEADER:
            begin
                ftype   = b[7:4];
                len_acc = '0;
                len_cnt = '0;
                phase   = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                // seven bits per length byte, low group first
                len_acc = len_acc + (POS_W'(b[6:0]) << (7 * len_cnt[1:0]));
                len_cnt = len_cnt + 3'd1;
                if (b[7])
                begin
                    if (len_cnt >= MAX_LEN)
                    begin
                        phase  = PH_HALTED;
                        res.ev = EV_MALFORMED;
                        emit   = 1'b1;
                    end
                end
                else
                begin
                    remaining = len_acc;
                    index     = '0;
                    topic_len = '0;
                    pub_ok    = 1'b0;
                    if (len_acc == '0)
                    begin
                        phase    = PH_HEADER;
                        res.ev   = EV_EMPTY;
                        res.last = 1'b1;
                        emit     = 1'b1;
                    end
                    else
                        phase = PH_BODY;
                end
            end
            PH_BODY:
            begin
                pos      = index;
                res.ev   = EV_BODY;
                res.data = b;
                res.pos  = pos;
                res.sec  = SEC_OTHER;
                if (ftype == TYPE_PUBLISH)
                begin
                    if (len_acc < 2)
                        res.sec = SEC_DISCARD;
                    else if (pos == 0)
                        topic_len = {b, 8'h00};
                    else if (pos == 1)
                    begin
                        topic_len = topic_len | {8'h00, b};
                        pub_ok    = (32'(topic_len) + 2 <= 32'(len_acc));
                    end
                    else if (!pub_ok)
                        res.sec = SEC_DISCARD;
                    else if (32'(pos) < 32'(topic_len) + 2)
                        res.sec = SEC_TOPIC;
                    else
                        res.sec = SEC_PAYLOAD;
                end
                else if (ftype == TYPE_CONNACK && pos == 1 && len_acc >= 2 && b == 8'h00)
                    conn = 1'b1;
                index     = index + POS_W'(1);
                remaining = remaining - POS_W'(1);
                res.last  = (remaining == '0);
                if (res.last)
                    phase = PH_HEADER;
                emit = 1'b1;
            end
            default:
                ;
        endcase
        if (emit)
        begin
            res.ptype = ftype;
            res.conn  = conn;
            expected_q.push_back(res);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_result_t got;
        frame_result_t want;
        if (!rst_n)
        begin
            clear_parser();
            expected_q.delete();
            fail_count      <= 0;
            pending         <= 0;
            result_count    <= 0;
            body_count      <= 0;
            empty_count     <= 0;
            malformed_count <= 0;
        end
        else
        begin
            // a result word never leaves in the cycle its input word is taken
            if (m_tvalid && m_tready)
            begin
                got.ev    = m_tuser;
                got.ptype = m_tdata[3:0];
                got.data  = m_tdata[11:4];
                got.sec   = m_tdata[13:12];
                got.pos   = m_tdata[41:14];
                got.conn  = m_tdata[42];
                got.pad   = m_tdata[47:43];
                got.last  = m_tlast;
                result_count <= result_count + 1;
                if (got.ev == EV_BODY)
                    body_count <= body_count + 1;
                else if (got.ev == EV_EMPTY)
                    empty_count <= empty_count + 1;
                else if (got.ev == EV_MALFORMED)
                    malformed_count <= malformed_count + 1;
                if (expected_q.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result word ev=%0d type=%0d byte=%02h pos=%0d",
                                 got.ev, got.ptype, got.data, got.pos);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                        begin
                            $display("result %0d mismatch", result_count);
                            $write("  exp ev=%0d type=%0d byte=%02h sec=%0d",
                                   want.ev, want.ptype, want.data, want.sec);
                            $display(" pos=%0d last=%0d conn=%0d pad=%0h",
                                     want.pos, want.last, want.conn, want.pad);
                            $write("  got ev=%0d type=%0d byte=%02h sec=%0d",
                                   got.ev, got.ptype, got.data, got.sec);
                            $display(" pos=%0d last=%0d conn=%0d pad=%0h",
                                     got.pos, got.last, got.conn, got.pad);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                parse_word(s_tuser, s_tdata);
            pending <= expected_q.size();
        end
    end

endmodule

// ----- test/mqtt_frame_parser_tb.sv -----
// testbench top for the mqtt frame parser: drives byte traffic and gives the verdict
module mqtt_frame_parser_tb;
    import mqfp_pkg::*;

    localparam int RANDOM_WORDS = 800;
    localparam int HOLD_CYCLES  = 400;   // one long receiver stall to fill the queue
    localparam int IDLE_LIMIT   = 4000;  // well above the long stall plus worst gaps
    localparam int DRAIN_CYCLES = 20;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int words_sent;
    int resets_sent;
    int idle_cycles;
    int send_burst;
    int take_burst;
    int taken;

    int chk_fail;
    int chk_pending;
    int chk_results;
    int chk_body;
    int chk_empty;
    int chk_malformed;

    // directed words: bit 8 is the opcode, bits 7:0 the byte
    localparam logic [8:0] DIRECTED_WORDS [26] = '{
        {OP_RESET, 8'h5A},
        // connack with a zero return code sets the connected flag
        {OP_BYTE, 8'h20}, {OP_BYTE, 8'h02}, {OP_BYTE, 8'h00}, {OP_BYTE, 8'h00},
        // publish whose body is too short for a topic length
        {OP_BYTE, 8'h3F}, {OP_BYTE, 8'h01}, {OP_BYTE, 8'hAB},
        // publish whose topic length runs past the body end
        {OP_BYTE, 8'h30}, {OP_BYTE, 8'h04}, {OP_BYTE, 8'h00}, {OP_BYTE, 8'h05},
        {OP_BYTE, 8'h61}, {OP_BYTE, 8'h62},
        // empty frame with a padded four-byte length
        {OP_BYTE, 8'hF0}, {OP_BYTE, 8'h80}, {OP_BYTE, 8'h80}, {OP_BYTE, 8'h80},
        {OP_BYTE, 8'h00},
        // malformed length, then a dropped byte and a reset
        {OP_BYTE, 8'h00}, {OP_BYTE, 8'hFF}, {OP_BYTE, 8'hFF}, {OP_BYTE, 8'hFF},
        {OP_BYTE, 8'hFF}, {OP_BYTE, 8'hFF}, {OP_RESET, 8'h00}
    };

    mqtt_frame_parser u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    mqtt_frame_parser_chk u_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .fail_count      (chk_fail),
        .pending         (chk_pending),
        .result_count    (chk_results),
        .body_count      (chk_body),
        .empty_count     (chk_empty),
        .malformed_count (chk_malformed)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // random wait before each word, with occasional stretches of back-to-back words
    function automatic int draw_gap(inout int burst);
        int gap;
        if (burst > 0)
        begin
            burst = burst - 1;
            return 0;
        end
        gap = $urandom_range(0, 17);
        if ($urandom_range(0, 29) == 0)
            burst = $urandom_range(10, 40);
        return gap;
    endfunction

    // offer one word and hold it until the parser takes it
    task automatic send_word(input logic op, input logic [7:0] b, input bit ignored = 1'b0);
        int gap;
        gap = draw_gap(send_burst);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        if (!ignored)
            words_sent++;
        if (op == OP_RESET)
            resets_sent++;
    endtask

    // one well-formed frame: header, length code of len_bytes bytes, body
    task automatic send_packet(input logic [3:0] ptype, input int body_len, input int len_bytes);
        logic [15:0] topic_len;
        logic        zero_ack;
        logic [7:0]  b;
        // topic length mostly fits, sometimes overruns the body
        if ($urandom_range(0, 3) != 0 && body_len >= 2)
            topic_len = 16'($urandom_range(0, body_len - 2));
        else if ($urandom_range(0, 1) == 0)
            topic_len = 16'hFFFF;
        else
            topic_len = 16'($urandom_range(body_len - 1, 65535));
        zero_ack = ($urandom_range(0, 1) == 0);
        send_word(OP_BYTE, {ptype, 4'($urandom)});
        for (int i = 0; i < len_bytes; i++)
            send_word(OP_BYTE, {i < len_bytes - 1, 7'(body_len >> (7 * i))});
        for (int i = 0; i < body_len; i++)
        begin
            b = 8'($urandom);
            if (ptype == TYPE_PUBLISH && i == 0)
                b = topic_len[15:8];
            else if (ptype == TYPE_PUBLISH && i == 1)
                b = topic_len[7:0];
            else if (ptype == TYPE_CONNACK && i == 1 && zero_ack)
                b = 8'h00;
            send_word(OP_BYTE, b);
        end
    endtask

    // stall watchdog: any handshake restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, chk_pending);
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // result side: random stalls, plus one long hold-off once traffic is flowing
    initial
    begin : receiver
        int gap;
        bit held;
        held = 1'b0;
        wait (rst_n);
        forever
        begin
            gap = draw_gap(take_burst);
            if (!held && taken >= 150)
            begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            taken++;
        end
    end

    initial
    begin : stimulus
        int          pick;
        int          sel;
        int          body_len;
        int          len_bytes;
        int          lsel;
        logic [3:0]  ptype;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_WORDS[i])
            send_word(DIRECTED_WORDS[i][8], DIRECTED_WORDS[i][7:0]);

        while (words_sent < $size(DIRECTED_WORDS) + RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                // well-formed frame, biased toward publish and connack
                sel = $urandom_range(0, 9);
                if (sel < 4)
                    ptype = TYPE_PUBLISH;
                else if (sel < 6)
                    ptype = TYPE_CONNACK;
                else
                    ptype = 4'($urandom);
                lsel = $urandom_range(0, 19);
                if (lsel < 2)
                    body_len = 0;
                else if (lsel < 4)
                    body_len = 1;
                else if (lsel < 5)
                    body_len = 2;
                else if (lsel < 17)
                    body_len = $urandom_range(2, 24);
                else
                    body_len = $urandom_range(128, 260);
                len_bytes = (body_len < 128) ? 1 : 2;
                // sometimes pad the length code with zero groups up to four bytes
                if ($urandom_range(0, 3) == 0)
                    len_bytes = $urandom_range(len_bytes, 4);
                send_packet(ptype, body_len, len_bytes);
            end
            else if (pick < 78)
                send_word(OP_RESET, 8'($urandom));
            else if (pick < 86)
            begin
                // line noise, always cleaned up by a connection reset
                repeat ($urandom_range(1, 6))
                    send_word(($urandom_range(0, 3) == 0), 8'($urandom));
                send_word(OP_RESET, 8'($urandom));
            end
            else if (pick < 92)
            begin
                // four continuation bytes halt the parser; later bytes are dropped
                send_word(OP_BYTE, 8'($urandom));
                repeat (4)
                    send_word(OP_BYTE, 8'($urandom) | 8'h80);
                repeat ($urandom_range(0, 4))
                    send_word(OP_BYTE, 8'($urandom), 1'b1);
                send_word(OP_RESET, 8'($urandom));
            end
            else
            begin
                // huge four-byte length, cut short by a reset partway through the body
                send_word(OP_BYTE, 8'($urandom));
                repeat (3)
                    send_word(OP_BYTE, 8'($urandom) | 8'h80);
                send_word(OP_BYTE, {1'b0, 7'($urandom_range(1, 127))});
                repeat ($urandom_range(1, 10))
                    send_word(OP_BYTE, 8'($urandom));
                send_word(OP_RESET, 8'($urandom));
            end
        end
        s_tvalid <= 1'b0;
        @(posedge clk);

        wait (chk_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d input words including %0d connection resets; checked %0d results",
                 words_sent, resets_sent, chk_results);
        $display("results seen: %0d body bytes, %0d empty frames, %0d malformed lengths, %0d mismatches",
                 chk_body, chk_empty, chk_malformed, chk_fail);
        if (chk_fail == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/mqfp_pkg.sv
rtl/mqfp_front.sv
rtl/mqfp_queue.sv
rtl/mqfp_back.sv
rtl/mqtt_frame_parser.sv
rtl/mqfp_checker.sv
test/mqtt_frame_parser_chk.sv
test/mqtt_frame_parser_tb.sv
